### src/tlwbc_pkg.sv
// Shared types, constants and saturating helpers for the text line/word/byte counter.
package tlwbc_pkg;

	localparam int COUNT_WIDTH  = 48;
	localparam int COLUMN_WIDTH = 32;
	localparam int FILES_WIDTH  = 32;
	localparam int TAB_WIDTH_W  = 8;

	localparam logic [TAB_WIDTH_W-1:0]  TAB_WIDTH_RESET = 8'd8;
	localparam logic [COUNT_WIDTH-1:0]  CNT_MAX   = '1;
	localparam logic [COLUMN_WIDTH-1:0] COL_MAX   = '1;
	localparam logic [FILES_WIDTH-1:0]  FILES_MAX = '1;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_EOF  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0]  file_lines;
		logic [COUNT_WIDTH-1:0]  file_words;
		logic [COUNT_WIDTH-1:0]  file_bytes;
		logic [COLUMN_WIDTH-1:0] file_longest_line;
		logic [COUNT_WIDTH-1:0]  total_lines;
		logic [COUNT_WIDTH-1:0]  total_words;
		logic [COUNT_WIDTH-1:0]  total_bytes;
		logic [COLUMN_WIDTH-1:0] total_longest_line;
		logic [FILES_WIDTH-1:0]  files_seen;
	} out_t;

	// Per-file figures as they stand at end of file
	typedef struct packed {
		logic [COUNT_WIDTH-1:0]  lines;
		logic [COUNT_WIDTH-1:0]  words;
		logic [COUNT_WIDTH-1:0]  bytes;
		logic [COLUMN_WIDTH-1:0] longest;
	} file_sum_t;

	// Stage control: a beat leaves the input register this cycle
	typedef struct packed {
		logic fire;
		logic eof;
	} step_ctl_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_add_cnt(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b
	);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc_cnt(input logic [COUNT_WIDTH-1:0] a);
		return (a == CNT_MAX) ? CNT_MAX : a + 1'b1;
	endfunction

	function automatic logic [COLUMN_WIDTH-1:0] sat_add_col(
		input logic [COLUMN_WIDTH-1:0] a,
		input logic [COLUMN_WIDTH-1:0] b
	);
		logic [COLUMN_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COLUMN_WIDTH] ? COL_MAX : s[COLUMN_WIDTH-1:0];
	endfunction

endpackage

### src/tlwbc_file_stats.sv
// Per-file state: byte, word and line counts, column tracking with tab stops.
module tlwbc_file_stats import tlwbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  step_ctl_t              ctl,
	input  logic [7:0]             data_byte,
	input  logic [TAB_WIDTH_W-1:0] tab_width,
	input  logic                   cfg_we,
	output file_sum_t              summary
);

	logic [COUNT_WIDTH-1:0]  line_q, word_q, byte_q;
	logic [COLUMN_WIDTH-1:0] column_q, longest_q;
	logic [TAB_WIDTH_W-1:0]  rem_q;
	logic                    in_word_q;

	logic [COUNT_WIDTH-1:0]  line_d, word_d, byte_d;
	logic [COLUMN_WIDTH-1:0] column_d, longest_d;
	logic [TAB_WIDTH_W-1:0]  rem_d;
	logic                    in_word_d;

	logic [TAB_WIDTH_W-1:0]  w;
	logic [TAB_WIDTH_W-1:0]  tab_adv;
	logic [TAB_WIDTH_W:0]    rem_inc;
	logic [TAB_WIDTH_W-1:0]  rem_step;
	logic                    is_ws;

	// zero width behaves as one
	assign w        = (tab_width == '0) ? TAB_WIDTH_W'(1) : tab_width;
	assign tab_adv  = (rem_q < w) ? (w - rem_q) : TAB_WIDTH_W'(1);
	assign rem_inc  = {1'b0, rem_q} + (TAB_WIDTH_W+1)'(1);
	assign rem_step = (rem_inc >= {1'b0, w}) ? '0 : rem_inc[TAB_WIDTH_W-1:0];
	assign is_ws    = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
	                  (data_byte == CH_NEWLINE);

	// end-of-file view: open word counted, unfinished line measured
	assign summary.lines   = line_q;
	assign summary.bytes   = byte_q;
	assign summary.words   = in_word_q ? sat_inc_cnt(word_q) : word_q;
	assign summary.longest = (column_q > longest_q) ? column_q : longest_q;

	always_comb begin
		line_d    = line_q;
		word_d    = word_q;
		byte_d    = byte_q;
		column_d  = column_q;
		longest_d = longest_q;
		rem_d     = rem_q;
		in_word_d = in_word_q;
		if (ctl.fire && ctl.eof) begin
			line_d    = '0;
			word_d    = '0;
			byte_d    = '0;
			column_d  = '0;
			longest_d = '0;
			rem_d     = '0;
			in_word_d = 1'b0;
		end else if (ctl.fire) begin
			byte_d = sat_inc_cnt(byte_q);
			if (is_ws) begin
				if (in_word_q)
					word_d = sat_inc_cnt(word_q);
				in_word_d = 1'b0;
			end else begin
				in_word_d = 1'b1;
			end
			if (data_byte == CH_NEWLINE) begin
				if (column_q > longest_q)
					longest_d = column_q;
				column_d = '0;
				rem_d    = '0;
				line_d   = sat_inc_cnt(line_q);
			end else if (data_byte == CH_TAB) begin
				column_d = sat_add_col(column_q, COLUMN_WIDTH'(tab_adv));
				rem_d    = '0;
			end else begin
				column_d = sat_add_col(column_q, COLUMN_WIDTH'(1));
				rem_d    = rem_step;
			end
		end
		// new tab width: current column becomes a tab stop
		if (cfg_we)
			rem_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= '0;
			word_q    <= '0;
			byte_q    <= '0;
			column_q  <= '0;
			longest_q <= '0;
			rem_q     <= '0;
			in_word_q <= 1'b0;
		end else begin
			line_q    <= line_d;
			word_q    <= word_d;
			byte_q    <= byte_d;
			column_q  <= column_d;
			longest_q <= longest_d;
			rem_q     <= rem_d;
			in_word_q <= in_word_d;
		end
	end

endmodule

### src/tlwbc_totals.sv
// Running totals over files and the result register.
module tlwbc_totals import tlwbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_ctl_t ctl,
	input  file_sum_t summary,
	output logic      out_valid,
	input  logic      out_ready,
	output out_t      out_data
);

	logic [COUNT_WIDTH-1:0]  sum_lines_q, sum_words_q, sum_bytes_q;
	logic [COLUMN_WIDTH-1:0] sum_longest_q;
	logic [FILES_WIDTH-1:0]  files_q;
	logic                    out_valid_q;
	out_t                    out_data_q;

	logic [COUNT_WIDTH-1:0]  sum_lines_d, sum_words_d, sum_bytes_d;
	logic [COLUMN_WIDTH-1:0] sum_longest_d;
	logic [FILES_WIDTH-1:0]  files_d;
	logic                    close_file;

	assign close_file    = ctl.fire && ctl.eof;
	assign sum_lines_d   = sat_add_cnt(sum_lines_q, summary.lines);
	assign sum_words_d   = sat_add_cnt(sum_words_q, summary.words);
	assign sum_bytes_d   = sat_add_cnt(sum_bytes_q, summary.bytes);
	assign sum_longest_d = (summary.longest > sum_longest_q) ? summary.longest : sum_longest_q;
	assign files_d       = (files_q == FILES_MAX) ? FILES_MAX : files_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_lines_q   <= '0;
			sum_words_q   <= '0;
			sum_bytes_q   <= '0;
			sum_longest_q <= '0;
			files_q       <= '0;
			out_valid_q   <= 1'b0;
		end else if (close_file) begin
			sum_lines_q   <= sum_lines_d;
			sum_words_q   <= sum_words_d;
			sum_bytes_q   <= sum_bytes_d;
			sum_longest_q <= sum_longest_d;
			files_q       <= files_d;
			out_valid_q   <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close_file) begin
			out_data_q.file_lines         <= summary.lines;
			out_data_q.file_words         <= summary.words;
			out_data_q.file_bytes         <= summary.bytes;
			out_data_q.file_longest_line  <= summary.longest;
			out_data_q.total_lines        <= sum_lines_d;
			out_data_q.total_words        <= sum_words_d;
			out_data_q.total_bytes        <= sum_bytes_d;
			out_data_q.total_longest_line <= sum_longest_d;
			out_data_q.files_seen         <= files_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### src/text_line_word_byte_counter.sv
// Top level of the text line, word and byte counter.
//
// Counts lines, words, bytes and the widest line (tabs expanded to stops every
// tab_width columns) over a byte stream split into files. Each input beat is
// either a data byte or an end-of-file mark; only the end-of-file beat makes a
// result beat, carrying that file's figures, the running totals and the file
// count. A word still open and a last line without newline are both counted
// at end of file. All counters saturate. The block takes one beat per cycle
// unless stalled as below: a beat is registered in the input register on
// acceptance and applied to the per-file state as it leaves that register, so
// an end-of-file result is registered in the result register as its beat
// leaves the input register. The only stall comes from the single result
// register: an end-of-file beat waits in the input register while a previous
// result is held by out_ready low, and data bytes keep flowing otherwise.
// tab_width (reset 8, zero acts as one) is written through cfg_valid/cfg_data,
// always ready; write it only while the block is idle. A write makes the
// current column a tab stop.
module text_line_word_byte_counter import tlwbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_t                    in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_t                   out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [TAB_WIDTH_W-1:0] cfg_data
);

	logic                   valid_s1;
	in_t                    item_s1;
	logic [TAB_WIDTH_W-1:0] tab_width_q;
	logic                   cfg_we;
	step_ctl_t              ctl;
	file_sum_t              summary;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// data bytes always move on; end of file needs room in the result register
	assign ctl.eof  = (item_s1.mode == MODE_EOF);
	assign ctl.fire = valid_s1 && (!ctl.eof || !out_valid || out_ready);
	assign in_ready = !valid_s1 || ctl.fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q <= TAB_WIDTH_RESET;
		end else if (cfg_we) begin
			tab_width_q <= cfg_data;
		end
	end

	tlwbc_file_stats u_file_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (item_s1.data_byte),
		.tab_width (tab_width_q),
		.cfg_we    (cfg_we),
		.summary   (summary)
	);

	tlwbc_totals u_totals (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.summary   (summary),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
